/* src/avb_pkg.sv */
package avb_pkg;

    localparam int COLOR_W      = 16;
    localparam int ALPHA_W      = 13;
    localparam int LANES        = 3;
    localparam int Q_W          = COLOR_W;
    localparam int FRONT_STAGES = 4;
    localparam int LATENCY      = FRONT_STAGES + Q_W + 1;

    localparam logic [COLOR_W-1:0] COLOR_MAX = '1;
    localparam logic [ALPHA_W-1:0] ALPHA_MAX = '1;

    localparam int LANE_RED   = 0;
    localparam int LANE_GREEN = 1;
    localparam int LANE_BLUE  = 2;

    typedef logic [COLOR_W-1:0] t_color;
    typedef logic [ALPHA_W-1:0] t_alpha;

    typedef struct packed {
        t_color base_red;
        t_color base_green;
        t_color base_blue;
        t_alpha base_alpha;
        t_color mask_red;
        t_color mask_green;
        t_color mask_blue;
        t_alpha mask_alpha;
    } t_pix_in;

    typedef struct packed {
        t_color out_red;
        t_color out_green;
        t_color out_blue;
        t_alpha out_alpha;
        logic   empty_alpha;
    } t_pix_out;

    // flags and alpha that ride along with the quotients
    typedef struct packed {
        logic             empty;
        logic [LANES-1:0] sat;
        t_alpha           alpha;
    } t_side;

endpackage

/* src/avb_front.sv */
module avb_front import avb_pkg::*; #(
    parameter int FRAC_BITS = 12
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    input  t_pix_in                               i_pix,
    output logic                                  o_valid,
    output logic [LANES-1:0][2*FRAC_BITS+Q_W-1:0] o_num,
    output logic [2*FRAC_BITS:0]                  o_den,
    output t_side                                 o_side
);

    localparam int AW = FRAC_BITS + 1;
    localparam int EW = (AW > ALPHA_W) ? AW : ALPHA_W;
    localparam int DW = 2 * FRAC_BITS + 1;
    localparam int RW = 2 * FRAC_BITS;
    localparam int NW = RW + Q_W;
    localparam int PW = COLOR_W + AW;
    localparam int TW = COLOR_W + 2 * AW;
    localparam logic [AW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    logic [LANES-1:0][COLOR_W-1:0] c;
    logic [LANES-1:0][COLOR_W-1:0] mc;
    logic [EW-1:0]                 a_ext;
    logic [EW-1:0]                 ma_ext;
    logic [AW-1:0]                 a;
    logic [AW-1:0]                 ma;
    logic [EW-1:0]                 na_ext;

    logic                   r1_valid;
    logic [AW-1:0]          r1_a;
    logic [AW-1:0]          r1_ma;
    logic [AW-1:0]          r1_omm;
    logic [2*AW-1:0]        r1_ama;
    logic [LANES-1:0][PW-1:0] r1_mcma;
    logic [LANES-1:0][PW-1:0] r1_ca;

    logic                   r2_valid;
    logic [DW-1:0]          r2_den;
    logic [LANES-1:0][PW-1:0] r2_mcma;
    logic [LANES-1:0][TW-1:0] r2_t;

    logic                   r3_valid;
    logic [DW-1:0]          r3_den;
    logic [LANES-1:0][NW-1:0] r3_num;
    t_alpha                 r3_na;
    logic                   r3_empty;

    logic                   r4_valid;
    logic [DW-1:0]          r4_den;
    logic [LANES-1:0][NW-1:0] r4_num;
    t_side                  r4_side;

    assign c[LANE_RED]    = i_pix.base_red;
    assign c[LANE_GREEN]  = i_pix.base_green;
    assign c[LANE_BLUE]   = i_pix.base_blue;
    assign mc[LANE_RED]   = i_pix.mask_red;
    assign mc[LANE_GREEN] = i_pix.mask_green;
    assign mc[LANE_BLUE]  = i_pix.mask_blue;

    // opacity above one counts as one
    assign a_ext  = EW'(i_pix.base_alpha);
    assign ma_ext = EW'(i_pix.mask_alpha);
    assign a      = (a_ext > EW'(ONE)) ? ONE : AW'(a_ext);
    assign ma     = (ma_ext > EW'(ONE)) ? ONE : AW'(ma_ext);

    assign na_ext = EW'(r2_den[DW-1:FRAC_BITS]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        // stage 1: products of colors and opacities
        r1_a   <= a;
        r1_ma  <= ma;
        r1_omm <= ONE - ma;
        r1_ama <= (2*AW)'(a) * (2*AW)'(ma);
        for (int l = 0; l < LANES; l++) begin
            r1_mcma[l] <= PW'(mc[l]) * PW'(ma);
            r1_ca[l]   <= PW'(c[l]) * PW'(a);
        end

        // stage 2: base term times (one - ma), combined opacity scaled by one^2
        // the shifted sum may wrap, the difference is below 2^DW
        r2_den  <= ((DW'(r1_a) + DW'(r1_ma)) << FRAC_BITS) - DW'(r1_ama);
        r2_mcma <= r1_mcma;
        for (int l = 0; l < LANES; l++) begin
            r2_t[l] <= TW'(r1_ca[l]) * TW'(r1_omm);
        end

        // stage 3: channel numerators, result alpha
        r3_den   <= r2_den;
        r3_na    <= (na_ext > EW'(ALPHA_MAX)) ? ALPHA_MAX : na_ext[ALPHA_W-1:0];
        r3_empty <= (r2_den == '0);
        for (int l = 0; l < LANES; l++) begin
            r3_num[l] <= (NW'(r2_mcma[l]) << FRAC_BITS) + NW'(r2_t[l]);
        end

        // stage 4: quotient overflow check against the top of the numerator
        r4_den        <= r3_den;
        r4_num        <= r3_num;
        r4_side.empty <= r3_empty;
        r4_side.alpha <= r3_na;
        for (int l = 0; l < LANES; l++) begin
            r4_side.sat[l] <= (DW'(r3_num[l][NW-1:Q_W]) >= r3_den);
        end
    end

    assign o_valid = r4_valid;
    assign o_num   = r4_num;
    assign o_den   = r4_den;
    assign o_side  = r4_side;

endmodule

/* src/avb_div.sv */
module avb_div import avb_pkg::*; #(
    parameter int FRAC_BITS = 12
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    input  logic [LANES-1:0][2*FRAC_BITS+Q_W-1:0] i_num,
    input  logic [2*FRAC_BITS:0]                  i_den,
    input  t_side                                 i_side,
    output logic                                  o_valid,
    output logic [LANES-1:0][Q_W-1:0]             o_quot,
    output t_side                                 o_side
);

    localparam int DW = 2 * FRAC_BITS + 1;
    localparam int RW = 2 * FRAC_BITS;
    localparam int NW = RW + Q_W;

    // one restoring step per stage; the word shifts numerator bits out
    // at the top and quotient bits in at the bottom
    logic                          r_valid [Q_W];
    logic [LANES-1:0][RW-1:0]      r_rem   [Q_W];
    logic [LANES-1:0][Q_W-1:0]     r_word  [Q_W];
    logic [DW-1:0]                 r_den   [Q_W];
    t_side                         r_side  [Q_W];

    for (genvar s = 0; s < Q_W; s++) begin : g_step
        logic                      p_valid;
        logic [LANES-1:0][RW-1:0]  p_rem;
        logic [LANES-1:0][Q_W-1:0] p_word;
        logic [DW-1:0]             p_den;
        t_side                     p_side;
        logic [LANES-1:0][RW-1:0]  n_rem;
        logic [LANES-1:0][Q_W-1:0] n_word;

        if (s == 0) begin : g_first
            assign p_valid = i_valid;
            assign p_den   = i_den;
            assign p_side  = i_side;
            for (genvar l = 0; l < LANES; l++) begin : g_lane
                assign p_rem[l]  = i_num[l][NW-1:Q_W];
                assign p_word[l] = i_num[l][Q_W-1:0];
            end
        end else begin : g_next
            assign p_valid = r_valid[s-1];
            assign p_den   = r_den[s-1];
            assign p_side  = r_side[s-1];
            assign p_rem   = r_rem[s-1];
            assign p_word  = r_word[s-1];
        end

        always_comb begin
            for (int l = 0; l < LANES; l++) begin
                logic [DW-1:0] t;
                logic          qb;
                t  = {p_rem[l], p_word[l][Q_W-1]};
                qb = (t >= p_den);
                if (qb) begin
                    n_rem[l] = RW'(t - p_den);
                end else begin
                    n_rem[l] = t[RW-1:0];
                end
                n_word[l] = {p_word[l][Q_W-2:0], qb};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s] <= 1'b0;
            end else begin
                r_valid[s] <= p_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[s]  <= n_rem;
            r_word[s] <= n_word;
            r_den[s]  <= p_den;
            r_side[s] <= p_side;
        end
    end

    assign o_valid = r_valid[Q_W-1];
    assign o_quot  = r_word[Q_W-1];
    assign o_side  = r_side[Q_W-1];

endmodule

/* src/alpha_over_blend.sv */
// Straight-alpha "over" compositing of a mask color onto a base color, one
// pixel per clock with no gaps. A pixel is taken at each rising edge where
// start is high and busy is low; busy is low at all times outside reset, so
// a new pixel may follow in every cycle. Its blended result appears on o_pix
// from an output register, marked by o_valid for one cycle: four stages of
// multiply and add build the scaled numerators and the combined opacity, and
// sixteen stages of a restoring divider, one quotient bit each, give the
// three color channels. Results cannot be held off: the receiver must take
// each one in the cycle that o_valid is high. When both opacities are zero,
// empty_alpha is set and the colors and alpha come out as zero.
module alpha_over_blend import avb_pkg::*; #(
    parameter int FRAC_BITS = 12
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    input  t_pix_in  i_pix,
    output logic     busy,
    output logic     o_valid,
    output t_pix_out o_pix
);

    localparam int DW = 2 * FRAC_BITS + 1;
    localparam int NW = 2 * FRAC_BITS + Q_W;

    logic                      front_valid;
    logic [LANES-1:0][NW-1:0]  front_num;
    logic [DW-1:0]             front_den;
    t_side                     front_side;

    logic                      div_valid;
    logic [LANES-1:0][Q_W-1:0] div_quot;
    t_side                     div_side;

    logic [LANES-1:0][COLOR_W-1:0] color;
    t_pix_out                  n_pix;
    logic                      r_valid;
    t_pix_out                  r_pix;

    assign busy = !i_rst_n;

    avb_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_pix   (i_pix),
        .o_valid (front_valid),
        .o_num   (front_num),
        .o_den   (front_den),
        .o_side  (front_side)
    );

    avb_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .i_num   (front_num),
        .i_den   (front_den),
        .i_side  (front_side),
        .o_valid (div_valid),
        .o_quot  (div_quot),
        .o_side  (div_side)
    );

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            if (div_side.empty) begin
                color[l] = '0;
            end else if (div_side.sat[l]) begin
                color[l] = COLOR_MAX;
            end else begin
                color[l] = COLOR_W'(div_quot[l]);
            end
        end
        n_pix.out_red     = color[LANE_RED];
        n_pix.out_green   = color[LANE_GREEN];
        n_pix.out_blue    = color[LANE_BLUE];
        n_pix.out_alpha   = div_side.empty ? '0 : div_side.alpha;
        n_pix.empty_alpha = div_side.empty;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= div_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pix <= n_pix;
    end

    assign o_valid = r_valid;
    assign o_pix   = r_pix;

endmodule

/* src/avb_check.sv */
module avb_check import avb_pkg::*; (
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     start,
    input t_pix_in  i_pix,
    input logic     busy,
    input logic     o_valid,
    input t_pix_out o_pix
);

    // every transfer in gives one result a fixed number of cycles later
    a_latency_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_valid)
        else $error("accepted pixel produced no result");

    a_latency_rev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LATENCY))
        else $error("result without an accepted pixel");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_pix.empty_alpha) |->
            (o_pix.out_red == '0 && o_pix.out_green == '0 && o_pix.out_blue == '0
             && o_pix.out_alpha == '0
             && $past(i_pix.base_alpha == '0 && i_pix.mask_alpha == '0, LATENCY)))
        else $error("empty alpha flag inconsistent");

    a_alpha_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_pix.empty_alpha) |-> (o_pix.out_alpha != '0))
        else $error("zero alpha without empty flag");

endmodule

bind alpha_over_blend avb_check u_check (.*);
